// ===== sv/acs_pkg.sv =====
// Package: shared types, constants and codes for the accumulator CPU step core.
`default_nettype none
package acs_pkg;
	localparam int MEM_WORDS = 128;
	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [15:0] SP_RESET = 16'(MEM_WORDS - 1);

	localparam logic [3:0] MODE_IMM = 4'h8;
	localparam logic [3:0] MODE_DIR = 4'h9;
	localparam logic [3:0] MODE_A   = 4'hC;
	localparam logic [3:0] MODE_PA  = 4'hD;
	localparam logic [3:0] MODE_B   = 4'hE;
	localparam logic [3:0] MODE_PB  = 4'hF;

	localparam logic [7:0] OP_NOP  = 8'h00;
	localparam logic [7:0] OP_HALT = 8'h01;
	localparam logic [7:0] OP_CLRF = 8'h02;
	localparam logic [7:0] OP_MOV  = 8'h40;
	localparam logic [7:0] OP_READ = 8'h42;
	localparam logic [7:0] OP_WRIT = 8'h43;
	localparam logic [7:0] OP_PUSH = 8'h50;
	localparam logic [7:0] OP_POP  = 8'h51;
	localparam logic [7:0] OP_NOT  = 8'h80;
	localparam logic [7:0] OP_AND  = 8'h81;
	localparam logic [7:0] OP_OR   = 8'h82;
	localparam logic [7:0] OP_XOR  = 8'h83;
	localparam logic [7:0] OP_ADD  = 8'h84;
	localparam logic [7:0] OP_SUB  = 8'h85;
	localparam logic [7:0] OP_MUL  = 8'h86;
	localparam logic [7:0] OP_DIV  = 8'h87;
	localparam logic [7:0] OP_CALL = 8'hD0;
	localparam logic [7:0] OP_RET  = 8'hD1;
	localparam logic [7:0] OP_JMP  = 8'hCE;

	localparam logic [3:0] FL_HALT = 4'b0001;
	localparam logic [3:0] FL_ZERO = 4'b0010;
	localparam logic [3:0] FL_NEG  = 4'b0100;
	localparam logic [3:0] FL_POS  = 4'b1000;

	typedef struct packed {
		logic        cmd;
		logic [6:0]  addr;
		logic [15:0] data;
		logic signed [7:0] in_char;
	} in_item_t;

	typedef struct packed {
		logic        tty_valid;
		logic [7:0]  tty_char;
		logic        input_used;
		logic        halted;
		logic [15:0] prog_counter;
		logic [15:0] stack_ptr;
		logic [15:0] reg_a_out;
		logic [15:0] reg_b_out;
		logic [3:0]  flag_bits;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_LOAD, ST_FETCH, ST_OP1, ST_OP1IND, ST_OP2, ST_OP2IND,
		ST_EXEC, ST_DIV, ST_POPRD, ST_WB, ST_DONE
	} state_t;

	// read-address sources
	typedef enum logic [2:0] {
		RA_PC, RA_V1, RA_V2, RA_SP, RA_ADDR, RA_DIR
	} rsel_t;

	typedef struct packed {
		logic       clr_wr;     // write zero at clear counter
		logic       load_wr;    // external RAM write
		logic       rd_en;
		rsel_t      rsel;
		logic       pc_inc;
		logic       cap_ins;
		logic       cap_op1;    // capture op1 (register/immediate or ram data)
		logic       cap_op1_ram;
		logic       cap_op2;
		logic       cap_op2_ram;
		logic       exec;
		logic       div_start;
		logic       pop_cap;
		logic       wb;
		logic       done;
		logic       noexec;     // set on every start in idle: clears the tty and input-used flags
	} ctl_t;

	typedef struct packed {
		logic [3:0] m1;
		logic [3:0] m2;
		logic [7:0] opc;
		logic       halted;
		logic       div_busy;
		logic       clr_last;
	} sts_t;
endpackage
`default_nettype wire

// ===== sv/acs_div.sv =====
// Iterative 16-bit unsigned divider, one quotient bit per cycle.
`default_nettype none
module acs_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             busy,
	output logic [15:0]      quotient
);
	import acs_pkg::*;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] dvs_q;
	logic [16:0] trial;

	assign trial = {rem_q, quo_q[15]} - {1'b0, dvs_q};

	// restoring division step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd16;
		end else if (cnt_q != 5'd0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != 5'd0) begin
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[14:0], quo_q[15]};
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 5'd0);
	// divide by zero naturally yields all ones with restoring division
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== sv/acs_datapath.sv =====
// Datapath: RAM, registers, operand latches, ALU and result register.
`default_nettype none
module acs_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire acs_pkg::ctl_t   ctl,
	input  wire acs_pkg::in_item_t item,
	output acs_pkg::sts_t        sts,
	output acs_pkg::out_item_t   result
);
	import acs_pkg::*;

	logic [15:0] mem [MEM_WORDS];
	logic [15:0] rdata_q;
	logic [15:0] pc_q, sp_q, a_q, b_q;
	logic [3:0]  fl_q;
	logic [15:0] ins_q, v1_q, v2_q, dir1_q;
	logic [AW-1:0] clr_q;
	logic        tty_vld_q, in_used_q;
	logic [7:0]  tch_q;
	logic [AW-1:0] raddr, waddr;
	logic        we;
	logic [15:0] wdata;
	logic [15:0] rsrc;
	logic        div_busy;
	logic [15:0] quot;
	logic [15:0] mul_q;

	assign sts.opc = ins_q[15:8];
	assign sts.m1 = ins_q[7:4];
	assign sts.m2 = ins_q[3:0];
	assign sts.halted = fl_q[0];
	assign sts.div_busy = div_busy;
	assign sts.clr_last = (clr_q == AW'(MEM_WORDS - 1));

	// read address select
	always_comb begin
		case (ctl.rsel)
			RA_PC:   rsrc = pc_q;
			RA_V1:   rsrc = (sts.m1 == MODE_PA) ? a_q : b_q;
			RA_V2:   rsrc = (sts.m2 == MODE_PA) ? a_q : b_q;
			RA_SP:   rsrc = sp_q;
			RA_DIR:  rsrc = rdata_q;
			default: rsrc = pc_q;
		endcase
		raddr = rsrc[AW-1:0];
	end

	function automatic logic [15:0] regop(input logic [3:0] m, input logic [15:0] a,
			input logic [15:0] b);
		regop = (m == MODE_A) ? a : (m == MODE_B) ? b : 16'h0000;
	endfunction

	// write port: clear, load, push/call, write-back
	logic [15:0] res;
	logic        wb_mem;
	logic [15:0] wb_addr;
	always_comb begin
		unique case (sts.m1)
			MODE_DIR: begin wb_mem = 1'b1; wb_addr = dir1_q; end
			MODE_PA:  begin wb_mem = 1'b1; wb_addr = a_q; end
			MODE_PB:  begin wb_mem = 1'b1; wb_addr = b_q; end
			default:  begin wb_mem = 1'b0; wb_addr = a_q; end
		endcase
		we = 1'b0; waddr = '0; wdata = '0;
		if (ctl.clr_wr) begin
			we = 1'b1; waddr = clr_q;
		end else if (ctl.load_wr) begin
			we = 1'b1; waddr = item.addr[AW-1:0]; wdata = item.data;
		end else if (ctl.exec && sts.opc == OP_PUSH) begin
			we = 1'b1; waddr = sp_q[AW-1:0]; wdata = v1_q;
		end else if (ctl.exec && sts.opc == OP_CALL) begin
			we = 1'b1; waddr = sp_q[AW-1:0]; wdata = pc_q;
		end else if (ctl.wb && wb_mem) begin
			we = 1'b1; waddr = wb_addr[AW-1:0]; wdata = v1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (ctl.rd_en) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (ctl.clr_wr) clr_q <= clr_q + AW'(1);
	end

	acs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_start),
		.dividend(v1_q), .divisor(v2_q), .busy(div_busy), .quotient(quot)
	);

	// ALU on latched operands
	logic [15:0] v1n;
	logic        jmp;
	always_comb begin
		v1n = v1_q;
		case (sts.opc)
			OP_MOV: v1n = v2_q;
			OP_READ: v1n = (v2_q == 16'h0) ? {{8{item.in_char[7]}}, item.in_char} : 16'h0;
			OP_NOT: v1n = ~v1_q;
			OP_AND: v1n = v1_q & v2_q;
			OP_OR:  v1n = v1_q | v2_q;
			OP_XOR: v1n = v1_q ^ v2_q;
			OP_ADD: v1n = v1_q + v2_q;
			OP_SUB: v1n = v1_q - v2_q;
			default: v1n = v1_q;
		endcase
		jmp = (sts.opc[7:4] == 4'hC) &&
			((sts.opc == OP_JMP) || ((fl_q & sts.opc[3:0]) != 4'h0));
	end
	assign res = v1_q;

	function automatic logic [3:0] nzp(input logic [15:0] v);
		nzp = (v == 16'h0) ? FL_ZERO : v[15] ? FL_NEG : FL_POS;
	endfunction

	logic setfl;
	assign setfl = (sts.opc[7:6] == 2'b01) || (sts.opc[7:6] == 2'b10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0; sp_q <= SP_RESET; a_q <= '0; b_q <= '0; fl_q <= '0;
			tty_vld_q <= 1'b0; in_used_q <= 1'b0; tch_q <= '0;
		end else begin
			if (ctl.cap_ins) begin
				tty_vld_q <= 1'b0; in_used_q <= 1'b0; tch_q <= '0;
			end
			if (ctl.noexec) begin
				tty_vld_q <= 1'b0; in_used_q <= 1'b0; tch_q <= '0;
			end
			if (ctl.pc_inc) pc_q <= pc_q + 16'd1;
			if (ctl.exec) begin
				unique case (1'b1)
					(sts.opc == OP_HALT): fl_q <= fl_q | FL_HALT;
					(sts.opc == OP_CLRF): fl_q <= '0;
					(sts.opc == OP_PUSH): sp_q <= sp_q - 16'd1;
					(sts.opc == OP_POP):  sp_q <= sp_q + 16'd1;
					(sts.opc == OP_CALL): begin
						sp_q <= sp_q - 16'd1; pc_q <= v1_q;
					end
					(sts.opc == OP_RET): sp_q <= sp_q + 16'd1;
					jmp: pc_q <= v1_q;
					default: ;
				endcase
				if (sts.opc == OP_READ && v2_q == 16'h0) in_used_q <= 1'b1;
				if (sts.opc == OP_WRIT && v1_q == 16'h0) begin
					tty_vld_q <= 1'b1; tch_q <= v2_q[7:0];
				end
			end
			if (ctl.pop_cap && sts.opc == OP_RET) pc_q <= rdata_q;
			if (ctl.wb) begin
				if (setfl) fl_q <= nzp(res);
				if (sts.m1 == MODE_A) a_q <= res;
				if (sts.m1 == MODE_B) b_q <= res;
			end
		end
	end

	// operand and instruction latches; the direct address is taken with the address word
	always_ff @(posedge clk) begin
		if (ctl.cap_ins) ins_q <= rdata_q;
		if (ctl.cap_op1) begin
			v1_q <= ctl.cap_op1_ram ? rdata_q : regop(sts.m1, a_q, b_q);
			if (sts.m1 == MODE_DIR && ctl.rsel == RA_DIR) dir1_q <= rdata_q;
		end
		if (ctl.cap_op2) begin
			v2_q <= ctl.cap_op2_ram ? rdata_q : regop(sts.m2, a_q, b_q);
		end
		if (ctl.exec) begin
			mul_q <= 16'(v1_q * v2_q);
			if (sts.opc != OP_MUL && sts.opc != OP_DIV) v1_q <= v1n;
		end
		if (ctl.pop_cap) begin
			if (sts.opc == OP_POP) v1_q <= rdata_q;
			else if (sts.opc == OP_MUL) v1_q <= mul_q;
			else if (sts.opc == OP_DIV) v1_q <= quot;
		end
	end

	assign result.tty_valid = tty_vld_q;
	assign result.tty_char = tch_q;
	assign result.input_used = in_used_q;
	assign result.halted = fl_q[0];
	assign result.prog_counter = pc_q;
	assign result.stack_ptr = sp_q;
	assign result.reg_a_out = a_q;
	assign result.reg_b_out = b_q;
	assign result.flag_bits = fl_q;
endmodule
`default_nettype wire

// ===== sv/acs_ctrl.sv =====
// Controller: sequences clear, load, fetch, operand loads, execute and write-back.
`default_nettype none
module acs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           cmd,
	input  wire acs_pkg::sts_t  sts,
	output acs_pkg::ctl_t       ctl,
	output logic                busy,
	output logic                done
);
	import acs_pkg::*;
	state_t st_q, st_d;

	function automatic logic is_mem(input logic [3:0] m);
		is_mem = (m == MODE_DIR) || (m == MODE_PA) || (m == MODE_PB);
	endfunction
	function automatic logic is_pc(input logic [3:0] m);
		is_pc = (m == MODE_IMM) || (m == MODE_DIR);
	endfunction

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_CLEAR:  if (sts.clr_last) st_d = ST_IDLE;
			ST_IDLE:   if (start) st_d = (!cmd || sts.halted) ? ST_DONE : ST_LOAD;
			ST_LOAD:   st_d = ST_FETCH;
			ST_FETCH:  st_d = ST_OP1;
			ST_OP1:    st_d = (sts.m1 == MODE_DIR) ? ST_OP1IND : ST_OP2;
			ST_OP1IND: st_d = ST_OP2;
			ST_OP2:    st_d = (sts.m2 == MODE_DIR) ? ST_OP2IND : ST_EXEC;
			ST_OP2IND: st_d = ST_EXEC;
			ST_EXEC:   st_d = (sts.opc == OP_DIV) ? ST_DIV : ST_POPRD;
			ST_DIV:    if (!sts.div_busy) st_d = ST_POPRD;
			ST_POPRD:  st_d = ST_WB;
			ST_WB:     st_d = ST_DONE;
			ST_DONE:   st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_CLEAR;
		else st_q <= st_d;
	end

	// outputs
	always_comb begin
		ctl = '0;
		ctl.rsel = RA_PC;
		unique case (st_q)
			ST_CLEAR: ctl.clr_wr = 1'b1;
			ST_IDLE: begin
				if (start && !cmd) ctl.load_wr = 1'b1;
				if (start) ctl.noexec = 1'b1;
				ctl.rd_en = 1'b1; ctl.rsel = RA_PC;
			end
			ST_LOAD: begin
				// instruction word was read at PC in idle
				ctl.pc_inc = 1'b1; ctl.cap_ins = 1'b1;
			end
			ST_FETCH: begin
				// read immediate/address word or pointer target of op1
				ctl.rd_en = 1'b1;
				ctl.rsel = is_pc(sts.m1) ? RA_PC : RA_V1;
				ctl.pc_inc = is_pc(sts.m1);
			end
			ST_OP1: begin
				ctl.cap_op1 = 1'b1;
				ctl.cap_op1_ram = is_mem(sts.m1) || is_pc(sts.m1);
				ctl.rd_en = 1'b1;
				if (sts.m1 == MODE_DIR) begin
					ctl.rsel = RA_DIR;
				end else begin
					ctl.rsel = is_pc(sts.m2) ? RA_PC : RA_V2;
					ctl.pc_inc = is_pc(sts.m2);
				end
			end
			ST_OP1IND: begin
				// direct operand word arrives; start the op2 read
				ctl.cap_op1 = 1'b1; ctl.cap_op1_ram = 1'b1;
				ctl.rd_en = 1'b1;
				ctl.rsel = is_pc(sts.m2) ? RA_PC : RA_V2;
				ctl.pc_inc = is_pc(sts.m2);
			end
			ST_OP2: begin
				ctl.cap_op2 = 1'b1;
				ctl.cap_op2_ram = is_mem(sts.m2) || is_pc(sts.m2);
				if (sts.m2 == MODE_DIR) begin
					ctl.rd_en = 1'b1; ctl.rsel = RA_DIR;
				end
			end
			ST_OP2IND: begin
				ctl.cap_op2 = 1'b1; ctl.cap_op2_ram = 1'b1;
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				ctl.div_start = (sts.opc == OP_DIV);
				ctl.rd_en = 1'b1; ctl.rsel = RA_SP;
			end
			ST_DIV: ;
			ST_POPRD: begin
				ctl.pop_cap = 1'b1;
			end
			ST_WB: ctl.wb = 1'b1;
			ST_DONE: ctl.done = 1'b1;
			default: ;
		endcase
	end

	assign busy = (st_q != ST_IDLE);
	assign done = (st_q == ST_DONE);
endmodule
`default_nettype wire

// ===== sv/accumulator_cpu_step_core.sv =====
// Top level of the accumulator CPU step core.
`default_nettype none
// One transaction in, one result out. After reset the core clears its
// MEM_WORDS (128) RAM words with busy high. A RAM load or a halted step goes
// from idle straight to done; an instruction step walks fetch, operand, execute
// and write-back states set by the single-port RAM reads, and a divide waits
// for the divider (one quotient bit per cycle). The result appears with done
// for one cycle and cannot be held off; busy drops the next cycle.
module accumulator_cpu_step_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire acs_pkg::in_item_t   item,
	output logic                     busy,
	output logic                     done,
	output acs_pkg::out_item_t       result
);
	import acs_pkg::*;
	ctl_t ctl;
	sts_t sts;
	in_item_t item_q;
	in_item_t item_mux;

	// hold the transaction for the whole step
	always_ff @(posedge clk) begin
		if (start && !busy) item_q <= item;
	end
	assign item_mux = busy ? item_q : item;

	acs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(item.cmd),
		.sts(sts), .ctl(ctl), .busy(busy), .done(done)
	);

	acs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .item(item_mux),
		.sts(sts), .result(result)
	);
endmodule
`default_nettype wire
